// ----- design/hhfp_pkg.sv -----
// ----------------------------------------------------------------------------
// hhfp_pkg
// Shared types, codes and constants of the header field parser.
// ----------------------------------------------------------------------------
package hhfp_pkg;

  localparam int NAME_LIMIT  = 64;
  localparam int VALUE_LIMIT = 256;
  localparam int FIELD_LIMIT = 32;

  localparam logic [8:0] NAME_POS_MAX  = 9'(NAME_LIMIT - 1);
  localparam logic [8:0] VALUE_POS_MAX = 9'(VALUE_LIMIT - 1);
  localparam logic [5:0] FIELD_MAX     = 6'(FIELD_LIMIT);

  localparam logic [15:0] TOTAL_LIMIT_RST = 16'd4096;
  localparam logic [7:0]  BLANK_LIMIT_RST = 8'd254;
  localparam logic [15:0] TOTAL_SAT       = 16'hFFFF;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [0:0] {
    CFG_TOTAL_LIMIT = 1'b0,
    CFG_BLANK_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_NAME     = 3'd1,
    EV_VALUE    = 3'd2,
    EV_FIELD    = 3'd3,
    EV_BLOCK    = 3'd4,
    EV_ERROR    = 3'd5,
    EV_IGNORED  = 3'd6
  } event_t;

  typedef enum logic [6:0] {
    PH_NAME     = 7'b0000001,
    PH_NAME_CR  = 7'b0000010,
    PH_SEP      = 7'b0000100,
    PH_BLANK    = 7'b0001000,
    PH_VALUE    = 7'b0010000,
    PH_VALUE_CR = 7'b0100000,
    PH_END      = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    CC_NAME  = 3'd0,
    CC_COLON = 3'd1,
    CC_LF    = 3'd2,
    CC_CR    = 3'd3,
    CC_BLANK = 3'd4,
    CC_OTHER = 3'd5
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [7:0]  data_byte;
    logic        start_of_block;
  } item_t;

  typedef struct packed {
    logic [15:0] total_length_limit;
    logic [7:0]  blank_skip_limit;
  } cfg_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = CC_OTHER;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        c == CH_DASH || c == CH_DOT) begin
      r = CC_NAME;
    end else if (c == CH_COLON) begin
      r = CC_COLON;
    end else if (c == CH_LF) begin
      r = CC_LF;
    end else if (c == CH_CR) begin
      r = CC_CR;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      r = CC_BLANK;
    end
    return r;
  endfunction

endpackage

// ----- design/hhfp_stream_if.sv -----
// ----------------------------------------------------------------------------
// hhfp_stream_if
// Valid/ready channels for header bytes in and parse events out.
// ----------------------------------------------------------------------------
interface hhfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_block;

  modport source (output valid, output data_byte, output start_of_block, input ready);
  modport sink   (input valid, input data_byte, input start_of_block, output ready);
endinterface

interface hhfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] char_out;
  logic [4:0] field_index;
  logic [7:0] char_position;

  modport source (output valid, output event_kind, output char_out, output field_index,
                  output char_position, input ready);
  modport sink   (input valid, input event_kind, input char_out, input field_index,
                  input char_position, output ready);
endinterface

// ----- design/http_header_field_parser_core.sv -----
// ----------------------------------------------------------------------------
// http_header_field_parser_core
// Byte-at-a-time HTTP header field parser reporting one event per byte.
// ----------------------------------------------------------------------------
// The block takes one header byte per cycle while the output is not stalled
// and returns exactly one event per request, in order. Each accepted byte is
// queued, and its event is then registered at the output when it is free;
// the phase state machine in the back end handles one queued byte per cycle.
// A two-entry queue separates byte classification from parsing, so input is
// still taken for a while when the output is stalled. The user must write
// limits on the cfg_ port while no request is in flight; it is not enforced.
module http_header_field_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  hhfp_in_if.sink     in_ch,
  hhfp_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  hhfp_pkg::cfg_t  cfg_r;
  logic            q_full;
  logic            push;
  hhfp_pkg::item_t push_item;
  logic            q_valid;
  hhfp_pkg::item_t q_item;
  logic            pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_length_limit <= hhfp_pkg::TOTAL_LIMIT_RST;
      cfg_r.blank_skip_limit   <= hhfp_pkg::BLANK_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (hhfp_pkg::cfg_idx_t'(cfg_index))
        hhfp_pkg::CFG_TOTAL_LIMIT: cfg_r.total_length_limit <= cfg_wdata;
        hhfp_pkg::CFG_BLANK_LIMIT: cfg_r.blank_skip_limit   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  hhfp_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  hhfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (pop)
  );

  hhfp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- design/hhfp_front.sv -----
// ----------------------------------------------------------------------------
// hhfp_front
// Accepts header bytes and classifies each one for the back end.
// ----------------------------------------------------------------------------
module hhfp_front (
  hhfp_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output hhfp_pkg::item_t push_item
);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_item.cls            = hhfp_pkg::classify(in_ch.data_byte);
    push_item.data_byte      = in_ch.data_byte;
    push_item.start_of_block = in_ch.start_of_block;
  end

endmodule

// ----- design/hhfp_queue.sv -----
// ----------------------------------------------------------------------------
// hhfp_queue
// Two-entry queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module hhfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hhfp_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  output hhfp_pkg::item_t pop_item,
  input  logic            pop
);

  hhfp_pkg::item_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/hhfp_back.sv -----
// ----------------------------------------------------------------------------
// hhfp_back
// Phase state machine, counters and registered event output.
// ----------------------------------------------------------------------------
module hhfp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  hhfp_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  hhfp_pkg::item_t q_item,
  output logic            pop,
  hhfp_out_if.source      out_ch
);

  hhfp_pkg::phase_t phase_r, phase_nxt;
  logic [8:0]       pos_r, pos_nxt;
  logic [7:0]       blank_r, blank_nxt;
  logic [5:0]       field_r, field_nxt;
  logic [15:0]      total_r, total_nxt;

  logic             out_valid_r;
  hhfp_pkg::event_t ev_r, ev_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [4:0]       idx_r, idx_nxt;
  logic [7:0]       cpos_r, cpos_nxt;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_kind    = ev_r;
  assign out_ch.char_out      = char_r;
  assign out_ch.field_index   = idx_r;
  assign out_ch.char_position = cpos_r;

  always_comb begin
    hhfp_pkg::phase_t ph;
    logic [8:0]       pos;
    logic [7:0]       blank;
    logic [5:0]       field;
    logic [15:0]      total;
    logic [5:0]       field_inc;
    logic [15:0]      total_inc;
    logic             over_total;
    logic             end_field_err;

    ph    = q_item.start_of_block ? hhfp_pkg::PH_NAME : phase_r;
    pos   = q_item.start_of_block ? 9'd0  : pos_r;
    blank = q_item.start_of_block ? 8'd0  : blank_r;
    field = q_item.start_of_block ? 6'd0  : field_r;
    total = q_item.start_of_block ? 16'd0 : total_r;

    field_inc     = field + 6'd1;
    total_inc     = (total < hhfp_pkg::TOTAL_SAT) ? total + 16'd1 : total;
    over_total    = (total >= cfg.total_length_limit);
    end_field_err = over_total || (field_inc >= hhfp_pkg::FIELD_MAX);

    phase_nxt = ph;
    pos_nxt   = pos;
    blank_nxt = blank;
    field_nxt = field;
    total_nxt = total;
    ev_nxt    = hhfp_pkg::EV_CONSUMED;
    char_nxt  = 8'd0;
    idx_nxt   = field[4:0];
    cpos_nxt  = 8'd0;

    unique case (ph)
      hhfp_pkg::PH_NAME: begin
        case (q_item.cls)
          hhfp_pkg::CC_NAME: begin
            if (pos >= hhfp_pkg::NAME_POS_MAX) begin
              phase_nxt = hhfp_pkg::PH_END;
              ev_nxt    = hhfp_pkg::EV_ERROR;
            end else begin
              ev_nxt    = hhfp_pkg::EV_NAME;
              char_nxt  = q_item.data_byte;
              cpos_nxt  = pos[7:0];
              pos_nxt   = pos + 9'd1;
              total_nxt = total_inc;
            end
          end
          hhfp_pkg::CC_COLON: phase_nxt = hhfp_pkg::PH_SEP;
          hhfp_pkg::CC_LF: begin
            phase_nxt = hhfp_pkg::PH_END;
            ev_nxt    = over_total ? hhfp_pkg::EV_ERROR : hhfp_pkg::EV_BLOCK;
          end
          hhfp_pkg::CC_CR: phase_nxt = hhfp_pkg::PH_NAME_CR;
          default: begin
            phase_nxt = hhfp_pkg::PH_END;
            ev_nxt    = hhfp_pkg::EV_ERROR;
          end
        endcase
      end
      hhfp_pkg::PH_NAME_CR: begin
        phase_nxt = hhfp_pkg::PH_END;
        if (q_item.cls == hhfp_pkg::CC_LF) begin
          ev_nxt = over_total ? hhfp_pkg::EV_ERROR : hhfp_pkg::EV_BLOCK;
        end else begin
          ev_nxt = hhfp_pkg::EV_ERROR;
        end
      end
      hhfp_pkg::PH_SEP: begin
        if (q_item.cls == hhfp_pkg::CC_BLANK) begin
          phase_nxt = hhfp_pkg::PH_BLANK;
          blank_nxt = 8'd0;
        end else begin
          phase_nxt = hhfp_pkg::PH_END;
          ev_nxt    = hhfp_pkg::EV_ERROR;
        end
      end
      hhfp_pkg::PH_BLANK: begin
        if (blank >= cfg.blank_skip_limit) begin
          phase_nxt = hhfp_pkg::PH_END;
          ev_nxt    = hhfp_pkg::EV_ERROR;
        end else begin
          case (q_item.cls)
            hhfp_pkg::CC_BLANK: blank_nxt = blank + 8'd1;
            hhfp_pkg::CC_LF: begin
              field_nxt = field_inc;
              pos_nxt   = 9'd0;
              blank_nxt = 8'd0;
              phase_nxt = end_field_err ? hhfp_pkg::PH_END : hhfp_pkg::PH_NAME;
              ev_nxt    = end_field_err ? hhfp_pkg::EV_ERROR : hhfp_pkg::EV_FIELD;
            end
            hhfp_pkg::CC_CR: phase_nxt = hhfp_pkg::PH_VALUE_CR;
            default: begin
              ev_nxt    = hhfp_pkg::EV_VALUE;
              char_nxt  = q_item.data_byte;
              pos_nxt   = 9'd1;
              phase_nxt = hhfp_pkg::PH_VALUE;
            end
          endcase
        end
      end
      hhfp_pkg::PH_VALUE: begin
        if (q_item.cls == hhfp_pkg::CC_LF) begin
          field_nxt = field_inc;
          pos_nxt   = 9'd0;
          blank_nxt = 8'd0;
          phase_nxt = end_field_err ? hhfp_pkg::PH_END : hhfp_pkg::PH_NAME;
          ev_nxt    = end_field_err ? hhfp_pkg::EV_ERROR : hhfp_pkg::EV_FIELD;
        end else if (q_item.cls == hhfp_pkg::CC_CR) begin
          phase_nxt = hhfp_pkg::PH_VALUE_CR;
        end else if (pos >= hhfp_pkg::VALUE_POS_MAX) begin
          phase_nxt = hhfp_pkg::PH_END;
          ev_nxt    = hhfp_pkg::EV_ERROR;
        end else begin
          ev_nxt    = hhfp_pkg::EV_VALUE;
          char_nxt  = q_item.data_byte;
          cpos_nxt  = pos[7:0];
          pos_nxt   = pos + 9'd1;
          total_nxt = total_inc;
        end
      end
      hhfp_pkg::PH_VALUE_CR: begin
        if (q_item.cls == hhfp_pkg::CC_LF) begin
          field_nxt = field_inc;
          pos_nxt   = 9'd0;
          blank_nxt = 8'd0;
          phase_nxt = end_field_err ? hhfp_pkg::PH_END : hhfp_pkg::PH_NAME;
          ev_nxt    = end_field_err ? hhfp_pkg::EV_ERROR : hhfp_pkg::EV_FIELD;
        end else begin
          phase_nxt = hhfp_pkg::PH_END;
          ev_nxt    = hhfp_pkg::EV_ERROR;
        end
      end
      default: begin
        phase_nxt = hhfp_pkg::PH_END;
        ev_nxt    = hhfp_pkg::EV_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hhfp_pkg::PH_NAME;
      pos_r       <= 9'd0;
      blank_r     <= 8'd0;
      field_r     <= 6'd0;
      total_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        blank_r <= blank_nxt;
        field_r <= field_nxt;
        total_r <= total_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r   <= ev_nxt;
      char_r <= char_nxt;
      idx_r  <= idx_nxt;
      cpos_r <= cpos_nxt;
    end
  end

endmodule

// ----- design/hhfp_checker.sv -----
// ----------------------------------------------------------------------------
// hhfp_checker
// Port-level checks of the header field parser, bound to the top level.
// ----------------------------------------------------------------------------
module hhfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_kind,
  input logic [7:0] char_out,
  input logic [7:0] char_position
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_kind <= 3'(hhfp_pkg::EV_IGNORED))
    else $error("event code out of range");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind != 3'(hhfp_pkg::EV_NAME) &&
    event_kind != 3'(hhfp_pkg::EV_VALUE) |-> char_out == 8'd0 && char_position == 8'd0)
    else $error("character fields set on a non-character event");

  a_event_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("event without a matching request");

endmodule

bind http_header_field_parser_core hhfp_checker u_hhfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .event_kind    (out_ch.event_kind),
  .char_out      (out_ch.char_out),
  .char_position (out_ch.char_position)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the header field parser event by event. Each accepted byte goes
// through a local model of the parser state machine, and the outcome is
// queued in order. Every event that leaves the block is compared with the
// oldest queued one. The stimulus starts with a few short headers and a set
// of broken ones, then moves to random header blocks under several limit
// settings. The input side pauses and the output side stalls at random.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    hhfp_pkg::event_t kind;
    logic [7:0]       ch;
    logic [4:0]       idx;
    logic [7:0]       pos;
  } parse_event_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  hhfp_in_if  in_ch();
  hhfp_out_if out_ch();

  http_header_field_parser_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hhfp_pkg::phase_t ph;
  logic [8:0]       pos_cnt;
  logic [7:0]       blank_cnt;
  logic [5:0]       fld_cnt;
  logic [15:0]      total_cnt;
  logic [15:0]      lim_total;
  logic [7:0]       lim_blank;

  parse_event_t pending_events[$];
  int           mismatches;
  int           counted_items;
  int           burst_left;
  bit           sob_pending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit is_name_char(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == hhfp_pkg::CH_DASH || c == hhfp_pkg::CH_DOT;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == hhfp_pkg::CH_SPACE || c == hhfp_pkg::CH_TAB;
  endfunction

  function automatic void clear_parse_state();
    ph        = hhfp_pkg::PH_NAME;
    pos_cnt   = '0;
    blank_cnt = '0;
    fld_cnt   = '0;
    total_cnt = '0;
  endfunction

  function automatic void bump_total();
    if (total_cnt != hhfp_pkg::TOTAL_SAT) begin
      total_cnt = total_cnt + 16'd1;
    end
  endfunction

  function automatic hhfp_pkg::event_t close_block();
    ph = hhfp_pkg::PH_END;
    return (total_cnt >= lim_total) ? hhfp_pkg::EV_ERROR : hhfp_pkg::EV_BLOCK;
  endfunction

  function automatic hhfp_pkg::event_t close_field();
    fld_cnt   = fld_cnt + 6'd1;
    pos_cnt   = '0;
    blank_cnt = '0;
    if (total_cnt >= lim_total || fld_cnt >= hhfp_pkg::FIELD_MAX) begin
      ph = hhfp_pkg::PH_END;
      return hhfp_pkg::EV_ERROR;
    end
    ph = hhfp_pkg::PH_NAME;
    return hhfp_pkg::EV_FIELD;
  endfunction

  function automatic parse_event_t predict_event(logic [7:0] c, logic sob);
    parse_event_t e;
    e.kind = hhfp_pkg::EV_CONSUMED;
    e.ch   = '0;
    e.pos  = '0;
    if (sob) begin
      clear_parse_state();
    end
    e.idx = fld_cnt[4:0];
    case (ph)
      hhfp_pkg::PH_NAME: begin
        if (is_name_char(c)) begin
          if (pos_cnt >= hhfp_pkg::NAME_POS_MAX) begin
            ph     = hhfp_pkg::PH_END;
            e.kind = hhfp_pkg::EV_ERROR;
          end else begin
            e.kind  = hhfp_pkg::EV_NAME;
            e.ch    = c;
            e.pos   = pos_cnt[7:0];
            pos_cnt = pos_cnt + 9'd1;
            bump_total();
          end
        end else if (c == hhfp_pkg::CH_COLON) begin
          ph = hhfp_pkg::PH_SEP;
        end else if (c == hhfp_pkg::CH_LF) begin
          e.kind = close_block();
        end else if (c == hhfp_pkg::CH_CR) begin
          ph = hhfp_pkg::PH_NAME_CR;
        end else begin
          ph     = hhfp_pkg::PH_END;
          e.kind = hhfp_pkg::EV_ERROR;
        end
      end
      hhfp_pkg::PH_NAME_CR: begin
        if (c == hhfp_pkg::CH_LF) begin
          e.kind = close_block();
        end else begin
          ph     = hhfp_pkg::PH_END;
          e.kind = hhfp_pkg::EV_ERROR;
        end
      end
      hhfp_pkg::PH_SEP: begin
        if (is_blank(c)) begin
          ph        = hhfp_pkg::PH_BLANK;
          blank_cnt = '0;
        end else begin
          ph     = hhfp_pkg::PH_END;
          e.kind = hhfp_pkg::EV_ERROR;
        end
      end
      hhfp_pkg::PH_BLANK: begin
        if (blank_cnt >= lim_blank) begin
          ph     = hhfp_pkg::PH_END;
          e.kind = hhfp_pkg::EV_ERROR;
        end else if (is_blank(c)) begin
          blank_cnt = blank_cnt + 8'd1;
        end else if (c == hhfp_pkg::CH_LF) begin
          e.kind = close_field();
        end else if (c == hhfp_pkg::CH_CR) begin
          ph = hhfp_pkg::PH_VALUE_CR;
        end else begin
          e.kind  = hhfp_pkg::EV_VALUE;
          e.ch    = c;
          e.pos   = '0;
          pos_cnt = 9'd1;
          ph      = hhfp_pkg::PH_VALUE;
        end
      end
      hhfp_pkg::PH_VALUE: begin
        if (c == hhfp_pkg::CH_LF) begin
          e.kind = close_field();
        end else if (c == hhfp_pkg::CH_CR) begin
          ph = hhfp_pkg::PH_VALUE_CR;
        end else if (pos_cnt >= hhfp_pkg::VALUE_POS_MAX) begin
          ph     = hhfp_pkg::PH_END;
          e.kind = hhfp_pkg::EV_ERROR;
        end else begin
          e.kind  = hhfp_pkg::EV_VALUE;
          e.ch    = c;
          e.pos   = pos_cnt[7:0];
          pos_cnt = pos_cnt + 9'd1;
          bump_total();
        end
      end
      hhfp_pkg::PH_VALUE_CR: begin
        if (c == hhfp_pkg::CH_LF) begin
          e.kind = close_field();
        end else begin
          ph     = hhfp_pkg::PH_END;
          e.kind = hhfp_pkg::EV_ERROR;
        end
      end
      default: begin
        ph     = hhfp_pkg::PH_END;
        e.kind = hhfp_pkg::EV_IGNORED;
      end
    endcase
    return e;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sob);
    parse_event_t e;
    int           gap;
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.start_of_block <= sob;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    e = predict_event(b, sob);
    pending_events.push_back(e);
    counted_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // start_of_block rides on the first byte sent after sob_pending is set
  task automatic put(input logic [7:0] b);
    send_byte(b, sob_pending);
    sob_pending = 1'b0;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put(s[i]);
    end
  endtask

  task automatic put_crlf();
    put(hhfp_pkg::CH_CR);
    put(hhfp_pkg::CH_LF);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(input logic [15:0] total, input logic [7:0] blank);
    cfg_wr_en <= 1'b1;
    cfg_index <= hhfp_pkg::CFG_TOTAL_LIMIT;
    cfg_wdata <= total;
    @(posedge clk);
    lim_total = total;
    cfg_index <= hhfp_pkg::CFG_BLANK_LIMIT;
    cfg_wdata <= {8'h00, blank};
    @(posedge clk);
    lim_blank = blank;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_events
    parse_event_t e;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        $error("event_kind: expected none, got %0d", out_ch.event_kind);
        mismatches++;
      end else begin
        e = pending_events.pop_front();
        check_field("event_kind", {5'd0, e.kind}, {5'd0, out_ch.event_kind});
        check_field("char_out", e.ch, out_ch.char_out);
        check_field("field_index", {3'd0, e.idx}, {3'd0, out_ch.field_index});
        check_field("char_position", e.pos, out_ch.char_position);
      end
    end
  end

  initial begin : drive_ready
    rx_mode_t mode;
    int       left;
    out_ch.ready <= 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        RX_OPEN:  out_ch.ready <= 1'b1;
        RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:  out_ch.ready <= ((left % 7) < 4);
      endcase
    end
  end

  function automatic logic [7:0] random_name_char();
    int r;
    r = $urandom_range(0, 53);
    if (r < 26) begin
      return 8'h41 + 8'(r);
    end else if (r < 52) begin
      return 8'h61 + 8'(r - 26);
    end
    return (r == 52) ? hhfp_pkg::CH_DASH : hhfp_pkg::CH_DOT;
  endfunction

  function automatic logic [7:0] random_value_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    // keep most values on one line
    if ((b == hhfp_pkg::CH_CR || b == hhfp_pkg::CH_LF) && $urandom_range(0, 9) != 0) begin
      b = b ^ 8'h40;
    end
    return b;
  endfunction

  task automatic send_line_end(input int r);
    if (r == 0) begin
      put(hhfp_pkg::CH_CR);
      put(8'($urandom_range(0, 255)));
    end else if (r < 10) begin
      put(hhfp_pkg::CH_LF);
    end else begin
      put_crlf();
    end
  endtask

  task automatic send_random_block();
    int n_fields;
    int name_len;
    int extra;
    int val_len;
    sob_pending = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 29) == 0) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
      return;
    end
    n_fields = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 33) :
                                              $urandom_range(0, 5);
    for (int f = 0; f < n_fields; f++) begin
      name_len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 66) :
                                                $urandom_range(1, 10);
      for (int i = 0; i < name_len; i++) begin
        put(($urandom_range(0, 199) == 0) ? 8'($urandom_range(0, 255)) :
                                            random_name_char());
      end
      put(($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255)) :
                                         hhfp_pkg::CH_COLON);
      if ($urandom_range(0, 39) == 0) begin
        put(8'($urandom_range(0, 255)));
      end else begin
        put($urandom_range(0, 1) ? hhfp_pkg::CH_TAB : hhfp_pkg::CH_SPACE);
      end
      if ($urandom_range(0, 19) == 0) begin
        extra = int'(lim_blank) + $urandom_range(0, 2) - 1;
        if (extra < 0) begin
          extra = 0;
        end
      end else begin
        extra = $urandom_range(0, 3);
      end
      repeat (extra) put($urandom_range(0, 1) ? hhfp_pkg::CH_TAB : hhfp_pkg::CH_SPACE);
      val_len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 257) :
                                               $urandom_range(0, 16);
      repeat (val_len) put(random_value_byte());
      send_line_end($urandom_range(0, 19));
    end
    if ($urandom_range(0, 19) != 0) begin
      send_line_end($urandom_range(0, 19));
    end
    repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
  endtask

  task automatic run_random_blocks(input int quota);
    int first;
    first = counted_items;
    while (counted_items - first < quota) begin
      send_random_block();
    end
    wait_idle();
  endtask

  task automatic test_well_formed_block();
    sob_pending = 1'b1;
    put_text("Ho: a");
    put_crlf();
    put_text("X:");
    put(hhfp_pkg::CH_TAB);
    put(hhfp_pkg::CH_SPACE);
    put(8'h00);
    put(8'hFF);
    put(hhfp_pkg::CH_LF);
    put_crlf();
    put(8'h41);
  endtask

  task automatic test_error_cases();
    // bad name bytes
    sob_pending = 1'b1;
    put_text("a1");
    sob_pending = 1'b1;
    put(8'hFF);
    // lone cr in a name
    sob_pending = 1'b1;
    put(hhfp_pkg::CH_CR);
    put(8'h41);
    // missing separator
    sob_pending = 1'b1;
    put_text("A:x");
    // empty value, then block end
    sob_pending = 1'b1;
    put_text("A: ");
    put_crlf();
    put(hhfp_pkg::CH_LF);
    // lone cr in a value
    sob_pending = 1'b1;
    put_text("A: b");
    put(hhfp_pkg::CH_CR);
    put(8'h63);
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    write_limits(16'd1, 8'd1);
    run_random_blocks(100);
    write_limits(16'hFFFF, 8'hFF);
    run_random_blocks(150);
    write_limits(16'd0, 8'd0);
    run_random_blocks(50);
  endtask

  task automatic test_random_blocks();
    write_limits(16'($urandom_range(20, 300)), 8'($urandom_range(1, 6)));
    run_random_blocks(350);
    write_limits(hhfp_pkg::TOTAL_LIMIT_RST, hhfp_pkg::BLANK_LIMIT_RST);
    run_random_blocks(350);
    write_limits(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)));
    run_random_blocks(300);
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= hhfp_pkg::CFG_TOTAL_LIMIT;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.start_of_block <= 1'b0;
    mismatches    = 0;
    counted_items = 0;
    burst_left    = 0;
    sob_pending   = 1'b0;
    lim_total     = hhfp_pkg::TOTAL_LIMIT_RST;
    lim_blank     = hhfp_pkg::BLANK_LIMIT_RST;
    clear_parse_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_well_formed_block();
    test_error_cases();
    test_limit_extremes();
    test_random_blocks();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/hhfp_pkg.sv
design/hhfp_stream_if.sv
design/hhfp_front.sv
design/hhfp_queue.sv
design/hhfp_back.sv
design/http_header_field_parser_core.sv
design/hhfp_checker.sv
verif/testbench.sv
